/* src/json_string_unescape_utf8_defines.svh */
// Assertion macros shared by the queue and back end of the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Check that expr holds at every clock edge outside reset.
`define JSU_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define JSU_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/jsu_pkg.sv */
// Types, constants and helper functions of the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

   // Escape decoder phase
   typedef enum logic [2:0] {
      PH_NORMAL = 3'd0,
      PH_ESCAPE = 3'd1,
      PH_HEX0   = 3'd2,
      PH_HEX1   = 3'd3,
      PH_HEX2   = 3'd4,
      PH_HEX3   = 3'd5
   } phase_type;

   // What the back end has to emit for one request
   typedef enum logic [1:0] {
      JK_NONE = 2'd0,
      JK_BYTE = 2'd1,
      JK_CODE = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [15:0]  value;
      logic         term;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;

   localparam logic [7:0] CODE_BS  = 8'h08;
   localparam logic [7:0] CODE_FF  = 8'h0C;
   localparam logic [7:0] CODE_LF  = 8'h0A;
   localparam logic [7:0] CODE_CR  = 8'h0D;
   localparam logic [7:0] CODE_TAB = 8'h09;

   localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
   localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
   localparam logic [4:0]  SURROGATE_TOP  = 5'b11011;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type h;
      h.ok  = 1'b1;
      h.val = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         h.val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.val = c[3:0] + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

/* src/jsu_front.sv */
// Front end: escape decoder that turns each request into at most one job for the queue.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_in_byte,
   input  wire logic                      req_end_of_string,
   input  wire jsu_pkg::queue_status_type q_status,
   output logic                           push,
   output jsu_pkg::job_type               push_job
);

   jsu_pkg::phase_type phase_ff, phase_in;
   logic [15:0]        accum_ff, accum_in;
   logic               stopped_ff, stopped_in;
   jsu_pkg::hex_type   hex;
   logic [15:0]        code_val;
   logic               accept;

   assign req_ready = q_status.not_full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= jsu_pkg::PH_NORMAL;
         accum_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         accum_ff   <= accum_in;
         stopped_ff <= stopped_in;
      end
   end

   always_comb begin
      hex            = jsu_pkg::hex_digit(req_in_byte);
      phase_in       = phase_ff;
      accum_in       = accum_ff;
      stopped_in     = stopped_ff;
      code_val       = accum_ff;
      push_job.kind  = jsu_pkg::JK_NONE;
      push_job.value = {8'h00, req_in_byte};
      push_job.term  = req_end_of_string;

      unique case (phase_ff)
         jsu_pkg::PH_ESCAPE: begin
            phase_in      = jsu_pkg::PH_NORMAL;
            push_job.kind = jsu_pkg::JK_BYTE;
            unique case (req_in_byte)
               jsu_pkg::CHAR_B: push_job.value = {8'h00, jsu_pkg::CODE_BS};
               jsu_pkg::CHAR_F: push_job.value = {8'h00, jsu_pkg::CODE_FF};
               jsu_pkg::CHAR_N: push_job.value = {8'h00, jsu_pkg::CODE_LF};
               jsu_pkg::CHAR_R: push_job.value = {8'h00, jsu_pkg::CODE_CR};
               jsu_pkg::CHAR_T: push_job.value = {8'h00, jsu_pkg::CODE_TAB};
               jsu_pkg::CHAR_U: begin
                  phase_in      = jsu_pkg::PH_HEX0;
                  accum_in      = '0;
                  stopped_in    = 1'b0;
                  push_job.kind = jsu_pkg::JK_NONE;
               end
               default: ;
            endcase
         end
         jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
            if (!stopped_ff) begin
               if (hex.ok) begin
                  code_val = {accum_ff[11:0], hex.val};
               end else begin
                  stopped_in = 1'b1;
               end
            end
            accum_in = code_val;
            unique case (phase_ff)
               jsu_pkg::PH_HEX0: phase_in = jsu_pkg::PH_HEX1;
               jsu_pkg::PH_HEX1: phase_in = jsu_pkg::PH_HEX2;
               jsu_pkg::PH_HEX2: phase_in = jsu_pkg::PH_HEX3;
               default: begin
                  phase_in       = jsu_pkg::PH_NORMAL;
                  accum_in       = '0;
                  stopped_in     = 1'b0;
                  push_job.value = code_val;
                  // surrogates cannot be converted: nothing to emit
                  push_job.kind  = (code_val[15:11] == jsu_pkg::SURROGATE_TOP) ?
                                   jsu_pkg::JK_NONE : jsu_pkg::JK_CODE;
               end
            endcase
         end
         default: begin
            if (req_in_byte == jsu_pkg::CHAR_BACKSLASH) begin
               phase_in = jsu_pkg::PH_ESCAPE;
            end else begin
               phase_in      = jsu_pkg::PH_NORMAL;
               push_job.kind = jsu_pkg::JK_BYTE;
            end
         end
      endcase

      // end of string drops any partial escape
      if (req_end_of_string) begin
         phase_in   = jsu_pkg::PH_NORMAL;
         accum_in   = '0;
         stopped_in = 1'b0;
      end
   end

   assign push = accept && ((push_job.kind != jsu_pkg::JK_NONE) || push_job.term);

endmodule

`default_nettype wire

/* src/jsu_queue.sv */
// Short job queue between the escape decoder and the byte emitter.
`timescale 1ns / 1ps
`default_nettype none

`include "json_string_unescape_utf8_defines.svh"

module jsu_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire jsu_pkg::job_type      push_job,
   input  wire logic                  pop,
   output jsu_pkg::job_type           head_job,
   output jsu_pkg::queue_status_type  q_status
);

   localparam int unsigned PTR_W = jsu_pkg::QUEUE_PTR_W;
   localparam int unsigned CNT_W = jsu_pkg::QUEUE_CNT_W;

   jsu_pkg::job_type mem_ff [jsu_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(jsu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(jsu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head_job           = mem_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.not_full  = (count_ff != CNT_W'(jsu_pkg::QUEUE_DEPTH));

   `JSU_ASSERT_IMPL(a_no_overflow, clock, reset, push, q_status.not_full, "push into full queue")
   `JSU_ASSERT_IMPL(a_no_underflow, clock, reset, pop, q_status.not_empty, "pop from empty queue")
   `JSU_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(jsu_pkg::QUEUE_DEPTH), "queue count out of range")
   `JSU_ASSERT_NEXT(a_ptr_gap, clock, reset, push && !pop && (count_ff == '0), q_status.not_empty && (rd_ptr_ff != wr_ptr_ff || jsu_pkg::QUEUE_DEPTH == 1), "queue pointers out of step")

endmodule

`default_nettype wire

/* src/jsu_back.sv */
// Back end: UTF-8 encoding and byte-by-byte emission of queued jobs.
`timescale 1ns / 1ps
`default_nettype none

`include "json_string_unescape_utf8_defines.svh"

module jsu_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire jsu_pkg::job_type          head_job,
   input  wire jsu_pkg::queue_status_type q_status,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_out_last
);

   logic [1:0] idx_ff, idx_in;
   logic [1:0] n_bytes;
   logic [2:0] total;
   logic [2:0] idx_wide;
   logic [7:0] b0, b1, b2, sel;
   logic       at_term, final_out, fire;

   always_comb begin
      n_bytes = 2'd0;
      b0      = head_job.value[7:0];
      b1      = 8'h00;
      b2      = 8'h00;
      unique case (head_job.kind)
         jsu_pkg::JK_BYTE: n_bytes = 2'd1;
         jsu_pkg::JK_CODE: begin
            if (head_job.value < jsu_pkg::UTF8_ONE_LIMIT) begin
               n_bytes = 2'd1;
            end else if (head_job.value < jsu_pkg::UTF8_TWO_LIMIT) begin
               n_bytes = 2'd2;
               b0      = {3'b110, head_job.value[10:6]};
               b1      = {2'b10, head_job.value[5:0]};
            end else begin
               n_bytes = 2'd3;
               b0      = {4'b1110, head_job.value[15:12]};
               b1      = {2'b10, head_job.value[11:6]};
               b2      = {2'b10, head_job.value[5:0]};
            end
         end
         default: n_bytes = 2'd0;
      endcase

      unique case (idx_ff)
         2'd0:    sel = b0;
         2'd1:    sel = b1;
         default: sel = b2;
      endcase
   end

   assign total        = {1'b0, n_bytes} + {2'b00, head_job.term};
   assign idx_wide     = {1'b0, idx_ff};
   assign at_term      = (idx_ff == n_bytes);
   assign final_out    = ((idx_wide + 3'd1) == total);
   assign rsp_valid    = q_status.not_empty;
   assign rsp_out_byte = at_term ? 8'h00 : sel;
   assign rsp_out_last = head_job.term && at_term;
   assign fire         = rsp_valid && rsp_ready;
   assign pop          = fire && final_out;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = final_out ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `JSU_ASSERT_IMPL(a_job_not_empty, clock, reset, rsp_valid, total != 3'd0, "queued job has nothing to emit")
   `JSU_ASSERT_IMPL(a_idx_in_job, clock, reset, rsp_valid, idx_wide < total, "byte index beyond job")
   `JSU_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, $stable(idx_ff), "byte index moved while stalled")
   `JSU_ASSERT_IMPL(a_last_is_zero, clock, reset, rsp_valid && rsp_out_last, rsp_out_byte == 8'h00, "terminator not zero")

endmodule

`default_nettype wire

/* src/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps
`default_nettype none

// Unescapes the body of a JSON string, one request byte at a time, into
// UTF-8 bytes. Backslash escapes b, f, n, r and t become control codes, \u
// takes exactly four hex positions (a non-hex byte ends the number but the
// remaining positions are still consumed), any other escaped byte passes
// through, and surrogate code points give no bytes. A request flagged
// end_of_string is followed by a zero terminator byte with rsp_out_last set;
// an escape cut off by the end of the string is dropped. Requests are taken
// one per cycle while the two-entry job queue has room; each response byte
// waits for rsp_ready, so plain bytes stream at one per cycle while rsp_ready
// stays high, while a request that yields n response bytes (up to four:
// three UTF-8 bytes plus the terminator) holds the single-byte output port
// until all n are out, and req_ready drops once the queue fills behind such
// a burst. No clearing pass: the block is ready as soon as reset is released.

module json_string_unescape_utf8 (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_string,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);

   // job handed from the decoder to the emitter
   jsu_pkg::job_type          push_job;
   jsu_pkg::job_type          head_job;
   jsu_pkg::queue_status_type q_status;
   logic                      push;
   logic                      pop;

   // classify each request and track escape state
   jsu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .q_status          (q_status),
      .push              (push),
      .push_job          (push_job)
   );

   // hold jobs so decoder and emitter stall independently
   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // encode and emit each job one byte per response
   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

module testbench;

   // Give up well beyond the slowest legal run.
   localparam int unsigned CYCLE_LIMIT = 400000;
   // Cycles to linger once every expected byte has come out.
   localparam int unsigned DRAIN_CYCLES = 16;
   // Random requests per idling phase.
   localparam int unsigned PHASE_REQUESTS = 105;

   // One decoded byte as it leaves the block.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } utf8_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   // Decoder state as predicted from the accepted requests.
   jsu_pkg::phase_type esc_phase = jsu_pkg::PH_NORMAL;
   logic [15:0]        code_point = 16'h0000;
   logic               hex_ended = 1'b0;

   utf8_byte_type utf8_q[$];    // bytes still due on the response side
   logic [7:0]    body_q[$];    // string body waiting to be sent

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   json_string_unescape_utf8 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_last      (rsp_out_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Stall the response side at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Value of a hex digit in either case, or -1 for any other byte.
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   // ASCII hex digit for a nibble, upper or lower case.
   function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   function automatic void expect_byte(input logic [7:0] b, input logic last);
      utf8_byte_type e;
      e.data = b;
      e.last = last;
      utf8_q.push_back(e);
   endfunction

   // Work out the bytes one accepted request gives and queue them.
   function automatic void unescape_request(input logic [7:0] c, input logic eos);
      logic [7:0] lit;
      int         nib;
      case (esc_phase)
         jsu_pkg::PH_ESCAPE: begin
            lit = c;
            esc_phase = jsu_pkg::PH_NORMAL;
            case (c)
               jsu_pkg::CHAR_B: lit = jsu_pkg::CODE_BS;
               jsu_pkg::CHAR_F: lit = jsu_pkg::CODE_FF;
               jsu_pkg::CHAR_N: lit = jsu_pkg::CODE_LF;
               jsu_pkg::CHAR_R: lit = jsu_pkg::CODE_CR;
               jsu_pkg::CHAR_T: lit = jsu_pkg::CODE_TAB;
               jsu_pkg::CHAR_U: begin
                  esc_phase = jsu_pkg::PH_HEX0;
                  code_point = 16'h0000;
                  hex_ended = 1'b0;
               end
               default: ;
            endcase
            if (esc_phase == jsu_pkg::PH_NORMAL) expect_byte(lit, 1'b0);
         end
         jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
            // A non-hex byte freezes the number; later positions are eaten.
            if (!hex_ended) begin
               nib = hex_nibble(c);
               if (nib < 0) hex_ended = 1'b1;
               else code_point = {code_point[11:0], 4'(nib)};
            end
            if (esc_phase == jsu_pkg::PH_HEX3) begin
               if (code_point < jsu_pkg::UTF8_ONE_LIMIT) begin
                  expect_byte(code_point[7:0], 1'b0);
               end else if (code_point < jsu_pkg::UTF8_TWO_LIMIT) begin
                  expect_byte({3'b110, code_point[10:6]}, 1'b0);
                  expect_byte({2'b10, code_point[5:0]}, 1'b0);
               end else if (code_point[15:11] != jsu_pkg::SURROGATE_TOP) begin
                  // Surrogates fall through with nothing to emit.
                  expect_byte({4'b1110, code_point[15:12]}, 1'b0);
                  expect_byte({2'b10, code_point[11:6]}, 1'b0);
                  expect_byte({2'b10, code_point[5:0]}, 1'b0);
               end
               esc_phase = jsu_pkg::PH_NORMAL;
               code_point = 16'h0000;
               hex_ended = 1'b0;
            end else begin
               esc_phase = jsu_pkg::phase_type'(esc_phase + 3'd1);
            end
         end
         default: begin
            if (c == jsu_pkg::CHAR_BACKSLASH) esc_phase = jsu_pkg::PH_ESCAPE;
            else expect_byte(c, 1'b0);
         end
      endcase
      // End of string: drop any unfinished escape and close with the terminator.
      if (eos) begin
         esc_phase = jsu_pkg::PH_NORMAL;
         code_point = 16'h0000;
         hex_ended = 1'b0;
         expect_byte(8'h00, 1'b1);
      end
   endfunction

   // Compare every accepted response with the oldest byte still due.
   always @(posedge clock) begin
      utf8_byte_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (utf8_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: byte %02h last %0b", rsp_out_byte, rsp_out_last);
         end else begin
            due = utf8_q.pop_front();
            if (rsp_out_byte !== due.data || rsp_out_last !== due.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                           due.data, due.last, rsp_out_byte, rsp_out_last);
            end
         end
      end
   end

   // Offer one request, idling first at the current rate, and hold it until taken.
   task automatic send_request(input logic [7:0] c, input logic eos);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_in_byte <= c;
      req_end_of_string <= eos;
      do @(posedge clock); while (!req_ready);
      unescape_request(c, eos);
      requests_sent++;
   endtask

   // Send the staged string body, flagging its final byte as the end.
   task automatic send_body();
      for (int i = 0; i < body_q.size(); i++)
         send_request(body_q[i], i == body_q.size() - 1);
      body_q.delete();
   endtask

   task automatic test_plain_bytes();
      body_q = '{8'h00, 8'hFF};
      send_body();
   endtask

   task automatic test_simple_escapes();
      body_q = '{jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_B,
                 jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_F,
                 jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_N,
                 jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_R,
                 jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_T,
                 jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_BACKSLASH};
      send_body();
   endtask

   // Top of the three-byte range in mixed case, then a surrogate.
   task automatic test_code_points();
      body_q = '{jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_U,
                 hex_char(4'hF, 1'b1), hex_char(4'hF, 1'b0),
                 hex_char(4'hF, 1'b1), hex_char(4'hF, 1'b0),
                 jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_U,
                 hex_char(4'hD, 1'b0), hex_char(4'h8, 1'b0),
                 hex_char(4'h0, 1'b0), hex_char(4'h0, 1'b0)};
      send_body();
   endtask

   // A lone backslash at the end, then \u stopped by a non-hex byte at the end.
   task automatic test_cut_off_escapes();
      body_q = '{jsu_pkg::CHAR_BACKSLASH};
      send_body();
      body_q = '{jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_U, 8'h7A};
      send_body();
   endtask

   // Mostly well-formed strings with random content, plus noise and truncation.
   task automatic test_random_strings(input int unsigned count);
      int unsigned target;
      int unsigned tokens;
      int unsigned pick;
      int unsigned stop_at;
      logic [15:0] cp;
      logic [7:0]  c;
      target = requests_sent + count;
      while (requests_sent < target) begin
         tokens = $urandom_range(1, 8);
         for (int t = 0; t < tokens; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               do c = 8'($urandom_range(0, 255)); while (c == jsu_pkg::CHAR_BACKSLASH);
               body_q.push_back(c);
            end else if (pick < 45) begin
               body_q.push_back(jsu_pkg::CHAR_BACKSLASH);
               case ($urandom_range(0, 4))
                  0: body_q.push_back(jsu_pkg::CHAR_B);
                  1: body_q.push_back(jsu_pkg::CHAR_F);
                  2: body_q.push_back(jsu_pkg::CHAR_N);
                  3: body_q.push_back(jsu_pkg::CHAR_R);
                  default: body_q.push_back(jsu_pkg::CHAR_T);
               endcase
            end else if (pick < 52) begin
               // Escaped byte that is not a control letter passes through.
               c = 8'($urandom_range(0, 255));
               if (c == jsu_pkg::CHAR_B || c == jsu_pkg::CHAR_F || c == jsu_pkg::CHAR_N ||
                   c == jsu_pkg::CHAR_R || c == jsu_pkg::CHAR_T || c == jsu_pkg::CHAR_U)
                  c = 8'h22;
               body_q.push_back(jsu_pkg::CHAR_BACKSLASH);
               body_q.push_back(c);
            end else if (pick < 80) begin
               case ($urandom_range(0, 4))
                  0: cp = 16'($urandom_range(0, 16'h007F));
                  1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                  2: cp = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                               : 16'($urandom_range(16'hE000, 16'hFFFF));
                  3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
                  default: begin
                     case ($urandom_range(0, 9))
                        0: cp = 16'h0000;
                        1: cp = 16'h007F;
                        2: cp = 16'h0080;
                        3: cp = 16'h07FF;
                        4: cp = 16'h0800;
                        5: cp = 16'hD7FF;
                        6: cp = 16'hD800;
                        7: cp = 16'hDFFF;
                        8: cp = 16'hE000;
                        default: cp = 16'hFFFF;
                     endcase
                  end
               endcase
               body_q.push_back(jsu_pkg::CHAR_BACKSLASH);
               body_q.push_back(jsu_pkg::CHAR_U);
               for (int d = 3; d >= 0; d--)
                  body_q.push_back(hex_char(cp[4*d +: 4], 1'($urandom_range(0, 1))));
            end else if (pick < 90) begin
               // Non-hex byte ends the number early; later positions are anything.
               stop_at = $urandom_range(0, 3);
               body_q.push_back(jsu_pkg::CHAR_BACKSLASH);
               body_q.push_back(jsu_pkg::CHAR_U);
               for (int d = 0; d < 4; d++) begin
                  if (d < stop_at) begin
                     c = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                  end else if (d == stop_at) begin
                     do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
                  end else begin
                     c = 8'($urandom_range(0, 255));
                  end
                  body_q.push_back(c);
               end
            end else begin
               body_q.push_back(8'($urandom_range(0, 255)));
            end
         end
         // Now and then cut the string off inside an escape.
         if ($urandom_range(0, 9) == 0) begin
            body_q.push_back(jsu_pkg::CHAR_BACKSLASH);
            if ($urandom_range(0, 1)) begin
               body_q.push_back(jsu_pkg::CHAR_U);
               repeat ($urandom_range(0, 3))
                  body_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                            1'($urandom_range(0, 1))));
            end
         end
         send_body();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part runs without idling.
      test_plain_bytes();
      test_simple_escapes();
      test_code_points();
      test_cut_off_escapes();

      // Random part across the idling phases.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_strings(PHASE_REQUESTS);
      send_idle_pct = 79;
      recv_stall_pct = 0;
      test_random_strings(PHASE_REQUESTS);
      send_idle_pct = 0;
      recv_stall_pct = 79;
      test_random_strings(PHASE_REQUESTS);
      send_idle_pct = 17;
      recv_stall_pct = 17;
      test_random_strings(PHASE_REQUESTS);

      // Drop valid, drain what is due, then linger for stray responses.
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (utf8_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && utf8_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
